// ----- rtl/core/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the min-heap priority queue: entry layout,
// result status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int KEY_W      = 32;
    localparam int PLD_W      = 9;
    localparam int ENT_W      = KEY_W + PLD_W;
    localparam int OCC_W      = 9;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;

    // operation kind carried on s_tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // one heap slot: key in the upper bits, payload handle below
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PLD_W-1:0] payload;
    } entry_t;

    // controller -> datapath, one strobe per micro-operation
    typedef struct packed {
        logic load;       // latch the accepted beat
        logic set_full;   // result: insert dropped
        logic set_empty;  // result: remove on empty heap
        logic up_issue;   // read parent of current slot
        logic up_move;    // parent moves down into hole, climb one level
        logic dn_root;    // read root and last entry
        logic dn_load;    // take minimum, last entry becomes the mover
        logic dn_move;    // chosen child moves up into hole, descend
        logic wr_cur;     // park the mover in the hole
        logic respond;    // load the output register, commit occupancy
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic idx_zero;
        logic up_less;
        logic pidx_zero;
        logic root_more;
        logic dn_swap;
        logic child_more;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/core/min_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap priority queue of (32-bit key, 9-bit handle) entries.
//
//   channel  dir  beat fields (low bit up)
//   s_       in   tuser: kind | tdata: key[31:0], payload[40:32]
//   m_       out  tdata: status[1:0], min_key[33:2], min_payload[42:34],
//                        occupancy[51:43]
//
// One beat at a time. An insert climbs one level per parent compare while the
// mover is strictly smaller, and a remove sinks one level per child compare
// while it is strictly greater. A dropped insert or a remove on an empty heap
// goes straight to the result without a RAM write.
// Each level is one RAM read-compare-write of the dual-read entry RAM.
// A finished result waits in the output register while the next beat is taken.
// A result is held back only while that register is still full.
// Synchronous active-low reset empties the heap.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_tuser,   // kind
    input  logic [S_TDATA_W-1:0] s_tdata,   // key, payload, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, min_key, min_payload, occupancy, pad
);

    cmd_t cmd;
    sts_t sts;

    mhpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/core/mhpq_ram.sv -----
// ----------------------------------------------------------------------------
// mhpq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 256
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                           rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/core/mhpq_dp.sv -----
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: entry RAM, hole index, moving entry, occupancy count,
// child/parent compares and the output register.
// ----------------------------------------------------------------------------
module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic                 s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    last_reg;
    logic [AW-1:0]    idx_reg;
    entry_t           cur_reg;
    logic             kind_reg;
    status_t          res_status_reg;
    logic [KEY_W-1:0] res_key_reg;
    logic [PLD_W-1:0] res_pld_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [ENT_W-1:0] rd_a_raw, rd_b_raw, wdata;
    entry_t           rd_a, rd_b, child_ent;
    logic [AW-1:0]    raddr_a, raddr_b, child;
    logic             we;

    logic [AW-1:0]    p_idx, pp_idx;
    logic [AW:0]      left_w, right_w, child_w, gleft_w, gright_w, last_ext;
    logic             pick_right;

    assign rd_a = entry_t'(rd_a_raw);
    assign rd_b = entry_t'(rd_b_raw);

    // index arithmetic: parent is (i-1)/2, children 2i+1 and 2i+2
    assign p_idx    = (idx_reg - AW'(1)) >> 1;
    assign pp_idx   = (p_idx - AW'(1)) >> 1;
    assign left_w   = {idx_reg, 1'b1};
    assign right_w  = {idx_reg, 1'b0} + (AW+1)'(2);
    assign last_ext = (AW+1)'(last_reg);

    // right child only when it exists and the left one is strictly greater
    assign pick_right = (right_w < last_ext) && (rd_a.key > rd_b.key);
    assign child_ent  = pick_right ? rd_b : rd_a;
    assign child_w    = pick_right ? right_w : left_w;
    assign child      = child_w[AW-1:0];
    assign gleft_w    = {child, 1'b1};
    assign gright_w   = {child, 1'b0} + (AW+1)'(2);

    // status back to the controller
    assign sts.kind       = kind_reg;
    assign sts.full       = (count_reg == CW'(CAPACITY));
    assign sts.empty      = (count_reg == '0);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.up_less    = (cur_reg.key < rd_a.key);
    assign sts.pidx_zero  = (p_idx == '0);
    assign sts.root_more  = ((AW+1)'(1) < last_ext);
    assign sts.dn_swap    = (cur_reg.key > child_ent.key);
    assign sts.child_more = (gleft_w < last_ext);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // read address selection
    always_comb begin
        raddr_a = p_idx;
        raddr_b = '0;
        priority if (cmd.up_move) begin
            raddr_a = pp_idx;
        end else if (cmd.dn_root) begin
            raddr_a = '0;
            raddr_b = AW'(count_reg - CW'(1));
        end else if (cmd.dn_load) begin
            raddr_a = AW'(1);
            raddr_b = AW'(2);
        end else if (cmd.dn_move) begin
            raddr_a = gleft_w[AW-1:0];
            raddr_b = gright_w[AW-1:0];
        end else if (cmd.up_issue) begin
            raddr_a = p_idx;
        end else begin
            raddr_a = p_idx;
        end
    end

    // write port: always into the current hole
    assign we = cmd.up_move || cmd.dn_move || cmd.wr_cur;
    always_comb begin
        priority if (cmd.up_move) begin
            wdata = ENT_W'(rd_a);
        end else if (cmd.dn_move) begin
            wdata = ENT_W'(child_ent);
        end else begin
            wdata = ENT_W'(cur_reg);
        end
    end

    mhpq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (idx_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a_raw),
        .raddr_b (raddr_b),
        .rdata_b (rd_b_raw)
    );

    // occupancy after this operation
    always_comb begin
        count_next = count_reg;
        if (res_status_reg == ST_DONE) begin
            if (kind_reg == KIND_INSERT) begin
                count_next = count_reg + CW'(1);
            end else begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    // output register valid
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.respond) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cmd.respond) begin
                count_reg <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg       <= s_tuser;
            cur_reg.key    <= s_tdata[KEY_W-1:0];
            cur_reg.payload <= s_tdata[KEY_W +: PLD_W];
            idx_reg        <= AW'(count_reg);
            res_status_reg <= ST_DONE;
            res_key_reg    <= '0;
            res_pld_reg    <= '0;
        end
        if (cmd.set_full) begin
            res_status_reg <= ST_FULL;
        end
        if (cmd.set_empty) begin
            res_status_reg <= ST_EMPTY;
        end
        if (cmd.dn_root) begin
            last_reg <= count_reg - CW'(1);
        end
        if (cmd.dn_load) begin
            res_key_reg <= rd_a.key;
            res_pld_reg <= rd_a.payload;
            cur_reg     <= rd_b;
            idx_reg     <= '0;
        end
        if (cmd.up_move) begin
            idx_reg <= p_idx;
        end
        if (cmd.dn_move) begin
            idx_reg <= child;
        end
        if (cmd.respond) begin
            m_tdata_reg <= M_TDATA_W'({OCC_W'(count_next), res_pld_reg, res_key_reg,
                                       res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // occupancy never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    // every RAM write lands inside the heap
    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> ((AW+1)'(idx_reg) < (AW+1)'(CAPACITY)))
        else $error("heap write outside capacity");

    // a dropped insert leaves the occupancy untouched
    a_full_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.respond && res_status_reg == ST_FULL) |=> $stable(count_reg))
        else $error("dropped insert changed occupancy");

endmodule

// ----- rtl/core/mhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Heap controller: sequences dispatch, sift-up, sift-down and the result
// hand-off, one micro-operation per cycle; the hand-off waits while the output register is full.
// ----------------------------------------------------------------------------
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_UP_CMP   = 7'b0000100,
        S_DN_LOAD  = 7'b0001000,
        S_DN_CMP   = 7'b0010000,
        S_FINAL_WR = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and command strobes
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.kind == KIND_INSERT) begin
                    if (sts.full) begin
                        cmd.set_full = 1'b1;
                        state_next   = S_RESP;
                    end else if (sts.idx_zero) begin
                        state_next = S_FINAL_WR;
                    end else begin
                        cmd.up_issue = 1'b1;
                        state_next   = S_UP_CMP;
                    end
                end else begin
                    if (sts.empty) begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_RESP;
                    end else begin
                        cmd.dn_root = 1'b1;
                        state_next  = S_DN_LOAD;
                    end
                end
            end
            // mover climbs while strictly smaller than its parent
            S_UP_CMP: begin
                if (sts.up_less) begin
                    cmd.up_move = 1'b1;
                    if (sts.pidx_zero) begin
                        state_next = S_FINAL_WR;
                    end
                end else begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_DN_LOAD: begin
                cmd.dn_load = 1'b1;
                state_next  = sts.root_more ? S_DN_CMP : S_FINAL_WR;
            end
            // mover sinks while strictly greater than the chosen child
            S_DN_CMP: begin
                if (sts.dn_swap) begin
                    cmd.dn_move = 1'b1;
                    if (!sts.child_more) begin
                        state_next = S_FINAL_WR;
                    end
                end else begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_FINAL_WR: begin
                cmd.wr_cur = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // an accepted beat always goes to dispatch next
    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_DISPATCH))
        else $error("accepted beat not dispatched");

    // no heap write while the input side is open
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.up_move || cmd.dn_move || cmd.wr_cur))
        else $error("heap write while idle");

    // a result handed to a free output register returns to idle
    a_resp_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && sts.out_free) |=> (state_reg == S_IDLE))
        else $error("result hand-off did not return to idle");

endmodule
